// ----- design/utf8s_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream sanitizer.
`timescale 1ns / 1ps

package utf8s_pkg;

  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0] AsciiMax    = 8'h7F;
  localparam logic [7:0] Lead2Mask   = 8'hE0;
  localparam logic [7:0] Lead2Code   = 8'hC0;
  localparam logic [7:0] Lead3Mask   = 8'hF0;
  localparam logic [7:0] Lead3Code   = 8'hE0;
  localparam logic [7:0] Lead4Mask   = 8'hF8;
  localparam logic [7:0] Lead4Code   = 8'hF0;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContCode    = 8'h80;
  localparam logic [7:0] ReplByte0   = 8'hEF;
  localparam logic [7:0] ReplByte1   = 8'hBF;
  localparam logic [7:0] ReplByte2   = 8'hBD;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // One request for the output side: up to four bytes, byte 0 first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } desc_t;

  // Status of the input side, watched at the top level.
  typedef struct packed {
    logic finished;
    logic pending;
  } front_status_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & Lead2Mask) == Lead2Code) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContCode;
  endfunction

  function automatic desc_t repl_desc();
    desc_t d;
    d.bytes    = {8'h00, ReplByte2, ReplByte1, ReplByte0};
    d.last_idx = 2'd2;
    return d;
  endfunction

endpackage

// ----- design/utf8s_front.sv -----
// Input side: accepts bytes, assembles multi-byte groups and classifies them.
`timescale 1ns / 1ps

module utf8s_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output utf8s_pkg::desc_t        push_desc_o,
  output utf8s_pkg::front_status_t status_o
);
  import utf8s_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      len_q, len_d;
  logic            fin_q, fin_d;

  logic            accept;
  logic [3:0][7:0] grp;
  logic            grp_ok;
  logic [2:0]      lead_len;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lead_len   = lead_length(data_byte_i);

  // The leader sits in slot 0; the newest byte closes the group at len-1.
  always_comb begin
    grp[0] = held_q[0];
    grp[1] = (len_q == 3'd2) ? data_byte_i : held_q[1];
    grp[2] = (len_q == 3'd3) ? data_byte_i : held_q[2];
    grp[3] = data_byte_i;
    grp_ok = is_cont(grp[1]);
    if (len_q >= 3'd3) begin
      grp_ok = grp_ok && is_cont(grp[2]);
    end
    if (len_q == 3'd4) begin
      grp_ok = grp_ok && is_cont(grp[3]);
    end
  end

  always_comb begin
    held_d      = held_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    fin_d       = fin_q;
    push_o      = 1'b0;
    push_desc_o = repl_desc();
    if (accept && !fin_q) begin
      if (mode_i == MODE_END) begin
        push_o = (cnt_q != 2'd0);
        cnt_d  = 2'd0;
        len_d  = 3'd0;
        fin_d  = 1'b1;
      end else if (cnt_q == 2'd0) begin
        if (data_byte_i <= AsciiMax) begin
          push_o               = 1'b1;
          push_desc_o.bytes    = {24'h000000, data_byte_i};
          push_desc_o.last_idx = 2'd0;
        end else if (lead_len != 3'd0) begin
          held_d[0] = data_byte_i;
          cnt_d     = 2'd1;
          len_d     = lead_len;
        end else begin
          push_o = 1'b1;
        end
      end else if (({1'b0, cnt_q} + 3'd1) < len_q) begin
        if (cnt_q != 2'd3) begin
          held_d[cnt_q] = data_byte_i;
        end
        cnt_d = cnt_q + 2'd1;
      end else begin
        push_o = 1'b1;
        if (grp_ok) begin
          push_desc_o.bytes    = grp;
          push_desc_o.last_idx = 2'(len_q - 3'd1);
        end
        cnt_d = 2'd0;
        len_d = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      len_q <= 3'd0;
      fin_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      len_q <= len_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  assign status_o.finished = fin_q;
  assign status_o.pending  = (cnt_q != 2'd0);

endmodule

// ----- design/utf8s_fifo.sv -----
// Short request queue between the input side and the output serialiser.
`timescale 1ns / 1ps

module utf8s_fifo #(
  parameter int unsigned Depth = utf8s_pkg::FifoDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8s_pkg::desc_t push_desc_i,
  output logic             full_o,
  output logic             valid_o,
  output utf8s_pkg::desc_t head_o,
  input  logic             pop_i
);
  import utf8s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// ----- design/utf8s_back.sv -----
// Output serialiser: sends queued bytes one per cycle when not stalled.
`timescale 1ns / 1ps

module utf8s_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  utf8s_pkg::desc_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);
  import utf8s_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       at_end;

  // The output register refills in the same cycle that its byte is taken.
  assign load    = q_valid_i && (!vld_q || out_ready_i);
  assign at_end  = (idx_q == q_head_i.last_idx);
  assign q_pop_o = load && at_end;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      byte_d = q_head_i.bytes[idx_q];
      last_d = at_end;
      idx_d  = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

// ----- design/utf8_stream_sanitizer.sv -----
// Top level of the UTF-8 stream sanitizer: input side, request queue, serialiser.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o | mode_i, data_byte_i
//   out     | output    | out_valid_o/out_ready_i | out_byte_o, last_o
//
// An input byte is taken every cycle while the request queue has room. Without
// stalls, each request leaves at one byte per cycle, so a group of n bytes holds
// the serialiser until all n are sent, and ASCII runs at one byte per cycle end
// to end. An input byte is queued, then registered, before it is offered. Reset
// clears the group assembly state, the finished flag and the queue. Either side
// may stall; the queue of FifoDepth requests takes up the slack.
`timescale 1ns / 1ps

module utf8_stream_sanitizer #(
  parameter int unsigned FifoDepth = utf8s_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       mode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);
  import utf8s_pkg::*;

  logic          push;
  desc_t         push_desc;
  logic          q_full;
  logic          q_valid;
  desc_t         q_head;
  logic          q_pop;
  front_status_t front_status;

  utf8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .data_byte_i(data_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_desc_o(push_desc),
    .status_o   (front_status)
  );

  utf8s_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_desc_i(push_desc),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  utf8s_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // A request is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("request pushed into a full queue");

  // Once the stream has finished, nothing further is queued.
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.finished |-> !push)
    else $error("request queued after end of stream");

  // A byte taken that is not the last of its group is followed by the next one.
  a_group_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("group broken off before its last byte");

  // Nothing is pending once the stream has finished.
  a_no_pending_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.finished |-> !front_status.pending)
    else $error("sequence still pending after end of stream");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the UTF-8 stream sanitizer, with directed, random and stall tests.
`timescale 1ns / 1ps

module tb;
  import utf8s_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_rec_t;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 80;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       mode      = MODE_DATA;
  logic [7:0] data_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  // Predictor state, kept in step with every request the block accepts.
  logic [7:0]  held [3];
  int unsigned held_cnt    = 0;
  int unsigned seq_span    = 0;
  bit          stream_done = 1'b0;
  bit          end_flushed = 1'b0;

  out_rec_t    sanitized_q [$];
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned hold_req = 0;

  int unsigned items_sent    = 0;
  int unsigned ignored_items = 0;
  int unsigned bytes_seen    = 0;
  int unsigned good_groups   = 0;
  int unsigned repl_count    = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;

  utf8_stream_sanitizer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .last_o      (out_last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned leader_span(input logic [7:0] b);
    casez (b)
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  function automatic logic [7:0] leader_of(input int unsigned span);
    case (span)
      2:       return {3'b110, 5'($urandom_range(0, 31))};
      3:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    out_rec_t rec;
    rec.value = b;
    rec.last  = last;
    sanitized_q.insert(sanitized_q.size(), rec);
  endtask

  task automatic push_replacement();
    push_byte(ReplByte0, 1'b0);
    push_byte(ReplByte1, 1'b0);
    push_byte(ReplByte2, 1'b1);
    repl_count++;
  endtask

  // Works out the bytes that one accepted request gives and queues them.
  task automatic predict_sanitized(input logic m, input logic [7:0] b);
    logic [7:0]  group [4];
    int unsigned span;
    int unsigned k;
    bit          intact;
    if (stream_done) begin
      ignored_items++;
      return;
    end
    if (m == MODE_END) begin
      end_flushed = (held_cnt != 0);
      if (held_cnt != 0) push_replacement();
      held_cnt    = 0;
      seq_span    = 0;
      stream_done = 1'b1;
      return;
    end
    if (held_cnt == 0) begin
      span = leader_span(b);
      if (b <= AsciiMax) begin
        push_byte(b, 1'b1);
      end else if (span == 0) begin
        push_replacement();
      end else begin
        held[0]  = b;
        held_cnt = 1;
        seq_span = span;
      end
      return;
    end
    span = seq_span;
    if (held_cnt + 1 < span) begin
      held[held_cnt] = b;
      held_cnt++;
      return;
    end
    for (k = 0; k < held_cnt; k++) group[k] = held[k];
    group[span-1] = b;
    held_cnt = 0;
    seq_span = 0;
    intact   = 1'b1;
    for (k = 1; k < span; k++) begin
      if ((group[k] & ContMask) != ContCode) intact = 1'b0;
    end
    if (intact) begin
      for (k = 0; k < span; k++) push_byte(group[k], k == span - 1);
      good_groups++;
    end else begin
      push_replacement();
    end
  endtask

  // Called at a rising edge; returns at the edge that takes the request.
  task automatic send_item(input logic m, input logic [7:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= b;
    do @(negedge clk); while (!in_ready);
    predict_sanitized(m, b);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_item(MODE_DATA, bytes[i]);
  endtask

  task automatic test_ascii_and_stray();
    send_bytes('{8'h00, 8'h7F, 8'h5A, 8'h80, 8'hBF, 8'hF8, 8'hFF});
  endtask

  task automatic test_directed_groups();
    send_bytes('{8'hC0, 8'h80});                 // overlong form passes unchecked
    send_bytes('{8'hE2, 8'h82, 8'hAC});
    send_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
    send_bytes('{8'hC3, 8'h41});                 // ASCII swallowed into a broken group
    send_bytes('{8'hE0, 8'hFF, 8'h80});
    send_bytes('{8'hF0, 8'h90, 8'h80, 8'hC0});
  endtask

  // Mostly well-formed characters with random content, the rest noise and broken groups.
  task automatic test_random_stream(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned span;
    int unsigned bad_at;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        send_item(MODE_DATA, 8'($urandom_range(0, 127)));
        sent++;
      end else if (pick <= 7) begin
        span   = $urandom_range(2, 4);
        bad_at = (pick == 7) ? $urandom_range(1, span - 1) : 0;
        send_item(MODE_DATA, leader_of(span));
        for (k = 1; k < span; k++) begin
          send_item(MODE_DATA, (k == bad_at) ? 8'($urandom_range(0, 255)) : cont_byte());
        end
        sent += span;
      end else begin
        send_item(MODE_DATA, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_stream(60);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the queue fills.
  task automatic test_output_stall();
    tx_quiet = 1'b1;
    hold_req = HoldCycles;
    test_random_stream(50);
    tx_quiet = 1'b0;
  endtask

  // Only one end of stream is possible per reset, so whether it flushes is drawn at random.
  task automatic test_end_of_stream();
    bit want_pending;
    want_pending = $urandom_range(0, 1);
    if (want_pending && held_cnt == 0) send_item(MODE_DATA, leader_of($urandom_range(2, 4)));
    while (!want_pending && held_cnt != 0) send_item(MODE_DATA, cont_byte());
    send_item(MODE_END, 8'($urandom_range(0, 255)));
    send_item(MODE_DATA, 8'h41);
    send_item(MODE_DATA, 8'($urandom_range(128, 255)));
    send_item(MODE_END, 8'h00);
    send_item(MODE_DATA, 8'hC2);
    in_valid <= 1'b0;
  endtask

  // Receiver: a random pause before each result, and a long hold when one is asked for.
  initial begin
    int unsigned pause;
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      pause = rx_quiet ? 0 : $urandom_range(0, 7);
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Handshakes are sampled at the falling edge, when every input is settled.
  always @(negedge clk) begin : check_output
    out_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_seen++;
      if (sanitized_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("byte %0d: nothing expected, got %02h last %0d", bytes_seen, out_byte,
                   out_last);
        end
      end else begin
        want = sanitized_q.pop_front();
        if (out_byte !== want.value || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("byte %0d: expected %02h last %0d, got %02h last %0d", bytes_seen,
                     want.value, want.last, out_byte, out_last);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no request moved for %0d cycles, %0d bytes still expected",
                 idle_cycles, sanitized_q.size());
        $display("utf8_stream_sanitizer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ascii_and_stray();
    test_directed_groups();
    test_random_stream(120);
    test_back_to_back();
    test_output_stall();
    test_end_of_stream();
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sanitized_q.size() != 0) mismatches++;
    $display("Sent %0d requests (%0d after end of stream), checked %0d output bytes.",
             items_sent, ignored_items, bytes_seen);
    $display("%0d groups passed whole, %0d replacements, end of stream %s a pending group.",
             good_groups, repl_count, end_flushed ? "flushed" : "found no");
    if (mismatches == 0) begin
      $display("utf8_stream_sanitizer: match");
    end else begin
      $display("utf8_stream_sanitizer: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/utf8s_pkg.sv
design/utf8s_front.sv
design/utf8s_fifo.sv
design/utf8s_back.sv
design/utf8_stream_sanitizer.sv
test/tb.sv
